// ===== design/spk_pkg.sv =====
// Shared constants and types for the spectral peak picker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

	localparam int LEVEL_W  = 24;
	localparam int FRAME_W  = 24;
	localparam int FRAC_W   = 16;
	localparam int BAND_W   = 6;
	localparam int THR_W    = LEVEL_W + FRAC_W;

	localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd19661;

	localparam int DEF_MAX_BANDS = 64;
	localparam int DEF_MAX_PEAKS = 10;

	// scan -> selector frame handoff
	typedef struct packed {
		logic               start;
		logic [FRAME_W-1:0] frame;
	} spk_start_t;

endpackage

`default_nettype wire

// ===== design/spk_if.sv =====
// Valid/ready channel interfaces for band requests and peak results.
// Depends on spk_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spk_in_if import spk_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] band_level;
	logic [FRAME_W-1:0] frame_number;
	logic               final_band;

	modport source (output valid, output band_level, output frame_number,
		output final_band, input ready);
	modport sink (input valid, input band_level, input frame_number,
		input final_band, output ready);
endinterface

interface spk_out_if import spk_pkg::*;;
	logic               valid;
	logic               ready;
	logic [BAND_W-1:0]  peak_band;
	logic [LEVEL_W-1:0] peak_level;
	logic [FRAME_W-1:0] peak_frame;
	logic               found;
	logic               end_of_list;

	modport source (output valid, output peak_band, output peak_level,
		output peak_frame, output found, output end_of_list, input ready);
	modport sink (input valid, input peak_band, input peak_level,
		input peak_frame, input found, input end_of_list, output ready);
endinterface

`default_nettype wire

// ===== design/spk_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing but the shared package import convention.
`timescale 1ns / 1ps
`default_nettype none

module spk_ram import spk_pkg::*; #(
	parameter int WIDTH = LEVEL_W,
	parameter int DEPTH = DEF_MAX_BANDS,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/spk_peak_scan.sv =====
// Band loader and local-maximum scan: fills the level store, then sweeps it
// once and writes qualifying bands to the candidate store. Uses spk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spk_peak_scan import spk_pkg::*; #(
	parameter int MAX_BANDS = DEF_MAX_BANDS,
	localparam int IW  = $clog2(MAX_BANDS),
	localparam int CW  = $clog2(MAX_BANDS + 1),
	localparam int CDW = IW + LEVEL_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [FRAC_W-1:0] cfg_wr_data,
	spk_in_if.sink                 band_in,
	output      logic              lvl_we,
	output      logic [IW-1:0]     lvl_waddr,
	output      logic [LEVEL_W-1:0] lvl_wdata,
	output      logic              lvl_re,
	output      logic [IW-1:0]     lvl_raddr,
	input  wire logic [LEVEL_W-1:0] lvl_rdata,
	output      logic              cand_we,
	output      logic [IW-1:0]     cand_waddr,
	output      logic [CDW-1:0]    cand_wdata,
	output      spk_start_t        start,
	output      logic [CW-1:0]     cand_count,
	input  wire logic              sel_busy
);

	typedef enum logic [2:0] {
		SC_LOAD = 3'b001,
		SC_WAIT = 3'b010,
		SC_SCAN = 3'b100
	} sc_state_t;

	sc_state_t          state_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      issue_q;
	logic [CW-1:0]      nc_q;
	logic [CW-1:0]      ncand_q;
	logic [LEVEL_W-1:0] max_q;
	logic [FRAME_W-1:0] frame_q;
	logic [THR_W-1:0]   thr_q;
	logic               start_q;
	logic               rd_v_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic [LEVEL_W-1:0] p1_q;
	logic [LEVEL_W-1:0] p2_q;

	logic               accept;
	logic               room;
	logic               is_cand;
	logic               scan_last;
	logic [CW-1:0]      nc_next;

	assign band_in.ready = (state_q == SC_LOAD);
	assign accept        = band_in.valid && band_in.ready;
	assign room          = cnt_q < CW'(MAX_BANDS);

	assign lvl_we    = accept && room;
	assign lvl_waddr = cnt_q[IW-1:0];
	assign lvl_wdata = band_in.band_level;

	assign lvl_re    = (state_q == SC_SCAN) && (issue_q < n_q);
	assign lvl_raddr = issue_q[IW-1:0];

	// band rd_idx_s1-1 sits in p1 with both neighbors at hand
	assign is_cand = rd_v_s1 && (rd_idx_s1 >= IW'(2))
		&& ({p1_q, {FRAC_W{1'b0}}} > thr_q)
		&& (p1_q >= p2_q) && (p1_q >= lvl_rdata);
	assign scan_last = rd_v_s1 && (CW'(rd_idx_s1) == n_q - 1'b1);
	assign nc_next   = nc_q + CW'(is_cand);

	assign cand_we    = is_cand;
	assign cand_waddr = nc_q[IW-1:0];
	assign cand_wdata = {rd_idx_s1 - 1'b1, p1_q};

	assign start      = '{start: start_q, frame: frame_q};
	assign cand_count = ncand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= FRAC_RESET;
		end else if (cfg_wr_en) begin
			frac_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			issue_q <= '0;
			nc_q    <= '0;
			ncand_q <= '0;
			max_q   <= '0;
			frame_q <= '0;
			start_q <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			start_q <= scan_last;
			rd_v_s1 <= lvl_re;
			case (state_q)
				SC_LOAD: begin
					if (accept) begin
						frame_q <= band_in.frame_number;
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
							if (band_in.band_level > max_q) begin
								max_q <= band_in.band_level;
							end
						end
						if (band_in.final_band) begin
							n_q     <= room ? cnt_q + 1'b1 : cnt_q;
							state_q <= SC_WAIT;
						end
					end
				end
				SC_WAIT: begin
					// candidate store is free once the selector drains
					if (!sel_busy) begin
						issue_q <= '0;
						nc_q    <= '0;
						cnt_q   <= '0;
						state_q <= SC_SCAN;
					end
				end
				SC_SCAN: begin
					if (lvl_re) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rd_v_s1) begin
						nc_q <= nc_next;
					end
					// hold the frame max through the sweep, drop it after
					if (scan_last) begin
						ncand_q <= nc_next;
						max_q   <= '0;
						state_q <= SC_LOAD;
					end
				end
				default: begin
					state_q <= SC_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		thr_q     <= max_q * frac_q;
		rd_idx_s1 <= issue_q[IW-1:0];
		if (rd_v_s1) begin
			p2_q <= p1_q;
			p1_q <= lvl_rdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/spk_topk_sel.sv =====
// Peak selector: emits candidates in band order, or runs one ranking pass
// over the candidate store per result. Holds the output register. Uses spk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spk_topk_sel import spk_pkg::*; #(
	parameter int MAX_BANDS = DEF_MAX_BANDS,
	parameter int MAX_PEAKS = DEF_MAX_PEAKS,
	localparam int IW  = $clog2(MAX_BANDS),
	localparam int CW  = $clog2(MAX_BANDS + 1),
	localparam int CDW = IW + LEVEL_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spk_start_t     start,
	input  wire logic [CW-1:0]  cand_count,
	output      logic           busy,
	output      logic           cand_re,
	output      logic [IW-1:0]  cand_raddr,
	input  wire logic [CDW-1:0] cand_rdata,
	spk_out_if.source           peak_out
);

	localparam int PW = $clog2(MAX_PEAKS + 1);
	localparam int EW = (IW > BAND_W) ? IW : BAND_W;

	typedef enum logic [2:0] {
		SL_IDLE  = 3'b001,
		SL_SWEEP = 3'b010,
		SL_EMIT  = 3'b100
	} sl_state_t;

	sl_state_t          state_q;
	logic [CW-1:0]      nc_q;
	logic [CW-1:0]      issue_q;
	logic [CW-1:0]      end_q;
	logic               top_q;
	logic [PW-1:0]      pass_q;
	logic               have_q;
	logic               rd_v_s1;
	logic               out_v_q;
	logic [CW-1:0]      rd_idx_s1;
	logic [FRAME_W-1:0] frame_q;
	logic [IW-1:0]      best_band_q;
	logic [LEVEL_W-1:0] best_lvl_q;
	logic [IW-1:0]      prev_band_q;
	logic [LEVEL_W-1:0] prev_lvl_q;
	logic [IW-1:0]      res_band_q;
	logic [LEVEL_W-1:0] res_lvl_q;
	logic               res_found_q;
	logic               res_last_q;
	logic [EW-1:0]      out_band_q;
	logic [LEVEL_W-1:0] out_lvl_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_found_q;
	logic               out_last_q;

	logic [IW-1:0]      c_band;
	logic [LEVEL_W-1:0] c_lvl;
	logic               elig;
	logic               better;
	logic               take;
	logic [IW-1:0]      pick_band;
	logic [LEVEL_W-1:0] pick_lvl;
	logic               sweep_last;
	logic               list_last;
	logic               load_out;
	logic               many;

	assign busy       = (state_q != SL_IDLE);
	assign cand_re    = (state_q == SL_SWEEP) && (issue_q <= end_q);
	assign cand_raddr = issue_q[IW-1:0];

	assign c_band = cand_rdata[CDW-1:LEVEL_W];
	assign c_lvl  = cand_rdata[LEVEL_W-1:0];

	// in a ranking pass, only bands ranked after the previous pick compete
	assign elig = !top_q || (pass_q == '0) || (c_lvl < prev_lvl_q)
		|| ((c_lvl == prev_lvl_q) && (c_band > prev_band_q));
	assign better = !have_q || (c_lvl > best_lvl_q)
		|| ((c_lvl == best_lvl_q) && (c_band < best_band_q));
	assign take      = rd_v_s1 && elig && better;
	assign pick_band = take ? c_band : best_band_q;
	assign pick_lvl  = take ? c_lvl : best_lvl_q;

	assign sweep_last = rd_v_s1 && (rd_idx_s1 == end_q);
	assign list_last  = top_q ? (pass_q == PW'(MAX_PEAKS - 1))
		: (end_q == nc_q - 1'b1);
	assign load_out   = (state_q == SL_EMIT) && (!out_v_q || peak_out.ready);
	assign many       = 32'(cand_count) > 32'(MAX_PEAKS);

	assign peak_out.valid       = out_v_q;
	assign peak_out.peak_band   = out_band_q[BAND_W-1:0];
	assign peak_out.peak_level  = out_lvl_q;
	assign peak_out.peak_frame  = out_frame_q;
	assign peak_out.found       = out_found_q;
	assign peak_out.end_of_list = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
			nc_q    <= '0;
			issue_q <= '0;
			end_q   <= '0;
			top_q   <= 1'b0;
			pass_q  <= '0;
			have_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= cand_re;
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (peak_out.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				SL_IDLE: begin
					if (start.start) begin
						nc_q    <= cand_count;
						top_q   <= many;
						pass_q  <= '0;
						issue_q <= '0;
						end_q   <= many ? cand_count - 1'b1 : '0;
						have_q  <= 1'b0;
						state_q <= (cand_count == '0) ? SL_EMIT : SL_SWEEP;
					end
				end
				SL_SWEEP: begin
					if (cand_re) begin
						issue_q <= issue_q + 1'b1;
					end
					if (take) begin
						have_q <= 1'b1;
					end
					if (sweep_last) begin
						state_q <= SL_EMIT;
					end
				end
				SL_EMIT: begin
					if (load_out) begin
						have_q <= 1'b0;
						if (res_last_q) begin
							state_q <= SL_IDLE;
						end else if (top_q) begin
							pass_q  <= pass_q + 1'b1;
							issue_q <= '0;
							state_q <= SL_SWEEP;
						end else begin
							issue_q <= end_q + 1'b1;
							end_q   <= end_q + 1'b1;
							state_q <= SL_SWEEP;
						end
					end
				end
				default: begin
					state_q <= SL_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q;
		if (state_q == SL_IDLE && start.start) begin
			frame_q     <= start.frame;
			res_band_q  <= '0;
			res_lvl_q   <= '0;
			res_found_q <= 1'b0;
			res_last_q  <= 1'b1;
		end
		if (take) begin
			best_band_q <= c_band;
			best_lvl_q  <= c_lvl;
		end
		if (state_q == SL_SWEEP && sweep_last) begin
			res_band_q  <= pick_band;
			res_lvl_q   <= pick_lvl;
			res_found_q <= 1'b1;
			res_last_q  <= list_last;
		end
		if (load_out) begin
			prev_band_q <= res_band_q;
			prev_lvl_q  <= res_lvl_q;
			out_band_q  <= EW'(res_band_q);
			out_lvl_q   <= res_lvl_q;
			out_frame_q <= frame_q;
			out_found_q <= res_found_q;
			out_last_q  <= res_last_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/spectral_peak_top_k.sv =====
// Spectral peak picker with top-k selection: top level.
// Band requests arrive on band_in (valid/ready); each carries band_level,
// frame_number and final_band. Bands load into the level store one per cycle;
// bands past MAX_BANDS are dropped, but their frame number still counts.
// After the final band the block waits until the previous frame's results
// have all entered the output register, forms the registered threshold
// (frame max times peak_fraction), then scans the level store at one band per
// cycle through its single read port. No input is taken from the final band
// until the scan ends.
// Results leave on peak_out (valid/ready). With at most MAX_PEAKS peaks each
// one is a candidate read, its data, then the emit; with more, each of the
// MAX_PEAKS results is one ranking pass over the whole candidate store. A
// frame with no peak gives one result with found low. The last result
// carries end_of_list.
// The output register holds a result while the receiver stalls; the selector
// then holds, and a new frame may load meanwhile. The user must write
// peak_fraction through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block does not enforce it. Reset clears all control state and sets
// peak_fraction to 19661 (about 0.3). Depends on spk_pkg, spk_in_if,
// spk_out_if, spk_ram, spk_peak_scan, spk_topk_sel.
`timescale 1ns / 1ps
`default_nettype none

module spectral_peak_top_k import spk_pkg::*; #(
	parameter int MAX_BANDS = DEF_MAX_BANDS,
	parameter int MAX_PEAKS = DEF_MAX_PEAKS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [FRAC_W-1:0] cfg_wr_data,
	spk_in_if.sink                 band_in,
	spk_out_if.source              peak_out
);

	localparam int IW  = $clog2(MAX_BANDS);
	localparam int CW  = $clog2(MAX_BANDS + 1);
	localparam int CDW = IW + LEVEL_W;

	// level store ports
	logic               lvl_we;
	logic [IW-1:0]      lvl_waddr;
	logic [LEVEL_W-1:0] lvl_wdata;
	logic               lvl_re;
	logic [IW-1:0]      lvl_raddr;
	logic [LEVEL_W-1:0] lvl_rdata;

	// candidate store ports: {band, level} per qualifying band
	logic               cand_we;
	logic [IW-1:0]      cand_waddr;
	logic [CDW-1:0]     cand_wdata;
	logic               cand_re;
	logic [IW-1:0]      cand_raddr;
	logic [CDW-1:0]     cand_rdata;

	// frame handoff between scan and selector
	spk_start_t         scan_start;
	logic [CW-1:0]      cand_count;
	logic               sel_busy;

	spk_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (MAX_BANDS)
	) u_level_store (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (lvl_wdata),
		.re    (lvl_re),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	spk_ram #(
		.WIDTH (CDW),
		.DEPTH (MAX_BANDS)
	) u_cand_store (
		.clk   (clk),
		.we    (cand_we),
		.waddr (cand_waddr),
		.wdata (cand_wdata),
		.re    (cand_re),
		.raddr (cand_raddr),
		.rdata (cand_rdata)
	);

	// load bands, then sweep the store once for local maxima
	spk_peak_scan #(
		.MAX_BANDS (MAX_BANDS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.band_in     (band_in),
		.lvl_we      (lvl_we),
		.lvl_waddr   (lvl_waddr),
		.lvl_wdata   (lvl_wdata),
		.lvl_re      (lvl_re),
		.lvl_raddr   (lvl_raddr),
		.lvl_rdata   (lvl_rdata),
		.cand_we     (cand_we),
		.cand_waddr  (cand_waddr),
		.cand_wdata  (cand_wdata),
		.start       (scan_start),
		.cand_count  (cand_count),
		.sel_busy    (sel_busy)
	);

	// order the candidates and drive the result channel
	spk_topk_sel #(
		.MAX_BANDS (MAX_BANDS),
		.MAX_PEAKS (MAX_PEAKS)
	) u_sel (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.cand_count (cand_count),
		.busy       (sel_busy),
		.cand_re    (cand_re),
		.cand_raddr (cand_raddr),
		.cand_rdata (cand_rdata),
		.peak_out   (peak_out)
	);

`ifndef SYNTHESIS
	// a new frame must never be handed over while the selector still reads
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start.start |-> !sel_busy)
		else $error("frame handed to busy selector");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start.start |=> sel_busy)
		else $error("selector did not pick up frame");

	// interior bands only: at most MAX_BANDS - 2 candidates
	a_cand_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start.start |-> (cand_count == '0)
			|| (32'(cand_count) + 32'd2 <= 32'(MAX_BANDS)))
		else $error("candidate count out of range");

	// the candidate store is never written while the selector sweeps it
	a_cand_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		cand_we |-> !sel_busy)
		else $error("candidate store written during selection");
`endif

endmodule

`default_nettype wire
